FILE: hdl/lhs_pkg.sv
package lhs_pkg;

	localparam int KIND_W = 3;
	localparam int BYTE_W = 8;
	localparam int EV_W = 3;
	localparam int LS_W = 2;
	localparam int TIME_W = 32;
	localparam int APB_AW = 5;
	localparam int APB_DW = 32;
	localparam int LHS_QDEPTH = 2;
	localparam int RES_MAX = 4;

	localparam logic [TIME_W-1:0] PING_INT_RST = 32'd5000;
	localparam logic [TIME_W-1:0] ACK_TO_RST = 32'd15000;
	localparam logic [TIME_W-1:0] RETRY_INT_RST = 32'd3000;

	// The acknowledgement text, matched one byte at a time.
	localparam logic [BYTE_W-1:0] ACK_TEXT [RES_MAX] = '{8'h50, 8'h4F, 8'h4E, 8'h47};

	typedef enum logic [KIND_W-1:0] {
		KIND_BYTE  = 3'd0,
		KIND_TICK  = 3'd1,
		KIND_CONN  = 3'd2,
		KIND_DISC  = 3'd3,
		KIND_RECON = 3'd4
	} kind_t;

	typedef enum logic [2:0] {
		REG_HB_EN     = 3'd0,
		REG_AUTO_RECON = 3'd1,
		REG_PING_INT  = 3'd2,
		REG_ACK_TO    = 3'd3,
		REG_RETRY_INT = 3'd4
	} reg_idx_t;

	typedef enum logic [2:0] {
		OP_NOP,
		OP_BYTE,
		OP_TICK,
		OP_CONN,
		OP_DISC,
		OP_RECON
	} op_t;

	typedef enum logic [EV_W-1:0] {
		EV_NONE    = 3'd0,
		EV_CONN    = 3'd1,
		EV_DISC    = 3'd2,
		EV_TIMEOUT = 3'd3,
		EV_PING    = 3'd4,
		EV_ACK     = 3'd5
	} ev_t;

	typedef enum logic [LS_W-1:0] {
		LS_DISC = 2'd0,
		LS_CONN = 2'd1,
		LS_ERR  = 2'd2
	} ls_t;

	typedef struct packed {
		logic       hit;
		logic [1:0] pos;
	} byte_cls_t;

	typedef struct packed {
		op_t       op;
		byte_cls_t cls;
	} q_entry_t;

	typedef struct packed {
		ev_t  ev;
		ls_t  ls;
		logic pend;
	} res_t;

	typedef struct packed {
		logic [1:0]           last_idx;
		res_t [RES_MAX-1:0]   r;
	} bundle_t;

	typedef struct packed {
		logic              hb_en;
		logic              auto_recon;
		logic [TIME_W-1:0] ping_int;
		logic [TIME_W-1:0] ack_to;
		logic [TIME_W-1:0] retry_int;
	} cfg_t;

endpackage

FILE: hdl/lhs_if.sv
interface lhs_in_if import lhs_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [KIND_W-1:0] kind;
	logic [BYTE_W-1:0] rx_byte;

	modport source (output valid, output kind, output rx_byte, input ready);
	modport sink (input valid, input kind, input rx_byte, output ready);
endinterface

interface lhs_out_if import lhs_pkg::*; ();
	logic            valid;
	logic            ready;
	logic [EV_W-1:0] event_res;
	logic [LS_W-1:0] link_state;
	logic            awaiting_ack;
	logic            last;

	modport source (output valid, output event_res, output link_state, output awaiting_ack,
		output last, input ready);
	modport sink (input valid, input event_res, input link_state, input awaiting_ack,
		input last, output ready);
endinterface

FILE: hdl/lhs_front.sv
module lhs_front import lhs_pkg::*; #(
	parameter int QDEPTH = LHS_QDEPTH
) (
	input  logic          clk,
	input  logic          arst_n,
	lhs_in_if.sink        item,
	output logic          q_valid,
	output q_entry_t      q_entry,
	input  logic          q_pop
);

	localparam int PW = $clog2(QDEPTH);
	localparam int CW = $clog2(QDEPTH + 1);

	q_entry_t        mem_q [QDEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   cnt_q;
	q_entry_t        cls_entry;
	logic            push;
	logic            pop;

	// Decode the kind and find which character of the ack text the byte is, if any.
	always_comb begin
		cls_entry = '0;
		unique case (kind_t'(item.kind))
			KIND_BYTE:  cls_entry.op = OP_BYTE;
			KIND_TICK:  cls_entry.op = OP_TICK;
			KIND_CONN:  cls_entry.op = OP_CONN;
			KIND_DISC:  cls_entry.op = OP_DISC;
			KIND_RECON: cls_entry.op = OP_RECON;
			default:    cls_entry.op = OP_NOP;
		endcase
		for (int i = 0; i < RES_MAX; i++) begin
			if (item.rx_byte == ACK_TEXT[i]) begin
				cls_entry.cls.hit = 1'b1;
				cls_entry.cls.pos = 2'(i);
			end
		end
	end

	assign item.ready = (cnt_q != CW'(QDEPTH));
	assign push = item.valid && item.ready;
	assign q_valid = (cnt_q != '0);
	assign pop = q_pop && q_valid;
	assign q_entry = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= cls_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

FILE: hdl/lhs_exec.sv
module lhs_exec import lhs_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  cfg_t     cfg,
	input  logic     q_valid,
	input  q_entry_t q_entry,
	output logic     q_pop,
	output logic     bnd_valid,
	output bundle_t  bnd,
	input  logic     bnd_ready
);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_TICK = 2'b10
	} st_t;

	st_t               state_q;
	logic [TIME_W-1:0] now_q;
	logic [TIME_W-1:0] ping_sent_q;
	logic [TIME_W-1:0] ack_seen_q;
	logic [TIME_W-1:0] rx_seen_q;
	logic [TIME_W-1:0] retry_q;
	logic [TIME_W-1:0] alive_q;
	logic              pending_q;
	logic [1:0]        match_q;
	ls_t               link_q;

	logic              take;
	logic              ping_due;
	logic              tmo_due;
	logic              retry_due;
	ls_t               link_n;
	logic              pend_n;
	logic [1:0]        match_n;
	logic              sess;
	logic              ping_st;
	logic              ack_st;
	logic              rx_st;
	logic              retry_st;
	logic              ping;
	logic              mok;
	logic [2:0]        n;
	res_t [RES_MAX-1:0] r;

	// Tick work is split in two: the time advances first, then the
	// three elapsed-time checks run side by side against the new time.
	assign ping_due = (now_q - ping_sent_q) >= cfg.ping_int;
	assign tmo_due = (now_q - alive_q) >= cfg.ack_to;
	assign retry_due = (now_q - retry_q) >= cfg.retry_int;

	assign take = (state_q == ST_IDLE) && q_valid && (q_entry.op == OP_TICK || bnd_ready);
	assign q_pop = take;

	always_comb begin
		bnd_valid = 1'b0;
		unique case (state_q)
			ST_IDLE: bnd_valid = take && (q_entry.op != OP_TICK);
			ST_TICK: bnd_valid = bnd_ready;
			default: bnd_valid = 1'b0;
		endcase
	end

	always_comb begin
		n = '0;
		r = '0;
		link_n = link_q;
		pend_n = pending_q;
		match_n = match_q;
		sess = 1'b0;
		ping_st = 1'b0;
		ack_st = 1'b0;
		rx_st = 1'b0;
		retry_st = 1'b0;
		ping = 1'b0;
		mok = 1'b0;
		if (state_q == ST_TICK) begin
			ping = cfg.hb_en && (link_q == LS_CONN) && ping_due;
			if (ping) begin
				ping_st = 1'b1;
				pend_n = 1'b1;
				r[n[1:0]] = '{ev: EV_PING, ls: LS_CONN, pend: 1'b1};
				n = n + 3'd1;
			end
			if (cfg.hb_en && (link_q == LS_CONN) && pend_n && tmo_due) begin
				r[n[1:0]] = '{ev: EV_TIMEOUT, ls: LS_ERR, pend: 1'b1};
				n = n + 3'd1;
				r[n[1:0]] = '{ev: EV_DISC, ls: LS_DISC, pend: 1'b0};
				n = n + 3'd1;
				link_n = LS_DISC;
				sess = 1'b1;
			end
			if (cfg.auto_recon && (link_n != LS_CONN) && retry_due) begin
				retry_st = 1'b1;
				r[n[1:0]] = '{ev: EV_CONN, ls: LS_CONN, pend: 1'b0};
				n = n + 3'd1;
				link_n = LS_CONN;
				sess = 1'b1;
			end
		end else begin
			unique case (q_entry.op)
				OP_BYTE: begin
					rx_st = 1'b1;
					ack_st = !pending_q;
					mok = q_entry.cls.hit && (q_entry.cls.pos == match_q);
					if (mok && (match_q == 2'd3)) begin
						match_n = '0;
						pend_n = 1'b0;
						ack_st = 1'b1;
						r[n[1:0]] = '{ev: EV_ACK, ls: link_q, pend: 1'b0};
						n = n + 3'd1;
					end else if (mok) begin
						match_n = match_q + 2'd1;
					end else begin
						match_n = {1'b0, q_entry.cls.hit && (q_entry.cls.pos == 2'd0)};
					end
				end
				OP_CONN: begin
					if (link_q != LS_CONN) begin
						link_n = LS_CONN;
						sess = 1'b1;
						r[n[1:0]] = '{ev: EV_CONN, ls: LS_CONN, pend: 1'b0};
						n = n + 3'd1;
					end
				end
				OP_DISC: begin
					if (link_q != LS_DISC) begin
						link_n = LS_DISC;
						sess = 1'b1;
						r[n[1:0]] = '{ev: EV_DISC, ls: LS_DISC, pend: 1'b0};
						n = n + 3'd1;
					end
				end
				OP_RECON: begin
					if (link_q != LS_DISC) begin
						r[n[1:0]] = '{ev: EV_DISC, ls: LS_DISC, pend: 1'b0};
						n = n + 3'd1;
					end
					link_n = LS_CONN;
					sess = 1'b1;
					r[n[1:0]] = '{ev: EV_CONN, ls: LS_CONN, pend: 1'b0};
					n = n + 3'd1;
				end
				OP_TICK, OP_NOP: begin
				end
				default: begin
				end
			endcase
		end
		if (sess) begin
			ping_st = 1'b1;
			ack_st = 1'b1;
			rx_st = 1'b1;
			pend_n = 1'b0;
			match_n = '0;
		end
		if (n == '0) begin
			r[0] = '{ev: EV_NONE, ls: link_n, pend: pend_n};
			n = 3'd1;
		end
		bnd.r = r;
		bnd.last_idx = 2'(n - 3'd1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			now_q <= '0;
			ping_sent_q <= '0;
			ack_seen_q <= '0;
			rx_seen_q <= '0;
			retry_q <= '0;
			alive_q <= '0;
			pending_q <= 1'b0;
			match_q <= '0;
			link_q <= LS_DISC;
		end else begin
			if (take && (q_entry.op == OP_TICK)) begin
				now_q <= now_q + 1'b1;
				alive_q <= (ack_seen_q > rx_seen_q) ? ack_seen_q : rx_seen_q;
				state_q <= ST_TICK;
			end
			if (bnd_valid) begin
				state_q <= ST_IDLE;
				link_q <= link_n;
				pending_q <= pend_n;
				match_q <= match_n;
				if (ping_st) begin
					ping_sent_q <= now_q;
				end
				if (ack_st) begin
					ack_seen_q <= now_q;
				end
				if (rx_st) begin
					rx_seen_q <= now_q;
				end
				if (retry_st) begin
					retry_q <= now_q;
				end
			end
		end
	end

endmodule

FILE: hdl/lhs_emit.sv
module lhs_emit import lhs_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       bnd_valid,
	input  bundle_t    bnd,
	output logic       bnd_ready,
	lhs_out_if.source  result
);

	bundle_t    bnd_q;
	logic [1:0] idx_q;
	logic       busy_q;
	res_t       cur;
	logic       at_last;
	logic       load;

	assign cur = bnd_q.r[idx_q];
	assign at_last = (idx_q == bnd_q.last_idx);

	assign result.valid = busy_q;
	assign result.event_res = cur.ev;
	assign result.link_state = cur.ls;
	assign result.awaiting_ack = cur.pend;
	assign result.last = at_last;

	// A new bundle may enter in the same cycle as the last result of the old one leaves.
	assign bnd_ready = !busy_q || (result.ready && at_last);
	assign load = bnd_valid && bnd_ready;

	always_ff @(posedge clk) begin
		if (load) begin
			bnd_q <= bnd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q <= '0;
		end else begin
			if (load) begin
				busy_q <= 1'b1;
				idx_q <= '0;
			end else if (busy_q && result.ready) begin
				if (at_last) begin
					busy_q <= 1'b0;
				end else begin
					idx_q <= idx_q + 2'd1;
				end
			end
		end
	end

endmodule

FILE: hdl/link_heartbeat_supervisor.sv
// Link heartbeat supervisor. Each input transaction is a received byte, a one-millisecond
// tick, or a connect, disconnect or reconnect request, and it produces one to four result
// transactions, the final one marked by last. Bytes feed a "PONG" matcher that keeps its
// progress across transactions; ticks advance the time, request pings, detect an
// unanswered ping and retry the connection. A front end decodes each input and places it
// in a small queue (QDEPTH entries); an execution stage consumes it, and an output stage
// hands out the results one per cycle while the receiver holds ready high. A byte or a
// request is executed as it is popped and its bundle is offered in the same cycle; a tick
// passes through the tick state first (the time increment is registered before the three
// elapsed-time comparisons). The output stage takes a new bundle as the last result of the
// old one leaves, so it is the limit on throughput. There is no clearing pass after reset.
// The five configuration registers lie at byte addresses 0, 4, 8, 12 and 16 of the APB
// port and should be written only while the block is idle.
module link_heartbeat_supervisor import lhs_pkg::*; #(
	parameter int QDEPTH = LHS_QDEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	lhs_in_if.sink            item,
	lhs_out_if.source         result,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready
);

	// Configuration registers, with their documented reset values.
	logic              hb_en_q;
	logic              auto_recon_q;
	logic [TIME_W-1:0] ping_int_q;
	logic [TIME_W-1:0] ack_to_q;
	logic [TIME_W-1:0] retry_int_q;
	cfg_t              cfg;
	logic              cfg_wr;
	reg_idx_t          reg_sel;

	// Queue and bundle handshakes between the three parts.
	logic              q_valid;
	q_entry_t          q_entry;
	logic              q_pop;
	logic              bnd_valid;
	bundle_t           bnd;
	logic              bnd_ready;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign reg_sel = reg_idx_t'(paddr[APB_AW-1:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hb_en_q <= 1'b1;
			auto_recon_q <= 1'b1;
			ping_int_q <= PING_INT_RST;
			ack_to_q <= ACK_TO_RST;
			retry_int_q <= RETRY_INT_RST;
		end else if (cfg_wr) begin
			unique case (reg_sel)
				REG_HB_EN:      hb_en_q <= pwdata[0];
				REG_AUTO_RECON: auto_recon_q <= pwdata[0];
				REG_PING_INT:   ping_int_q <= pwdata;
				REG_ACK_TO:     ack_to_q <= pwdata;
				REG_RETRY_INT:  retry_int_q <= pwdata;
				default: begin
				end
			endcase
		end
	end

	// Reads of unused addresses return zero.
	always_comb begin
		prdata = '0;
		unique case (reg_sel)
			REG_HB_EN:      prdata = {{(APB_DW-1){1'b0}}, hb_en_q};
			REG_AUTO_RECON: prdata = {{(APB_DW-1){1'b0}}, auto_recon_q};
			REG_PING_INT:   prdata = ping_int_q;
			REG_ACK_TO:     prdata = ack_to_q;
			REG_RETRY_INT:  prdata = retry_int_q;
			default:        prdata = '0;
		endcase
	end

	assign cfg.hb_en = hb_en_q;
	assign cfg.auto_recon = auto_recon_q;
	assign cfg.ping_int = ping_int_q;
	assign cfg.ack_to = ack_to_q;
	assign cfg.retry_int = retry_int_q;

	// The front end decodes the input transaction and queues it.
	lhs_front #(
		.QDEPTH(QDEPTH)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.item(item),
		.q_valid(q_valid),
		.q_entry(q_entry),
		.q_pop(q_pop)
	);

	// The execution stage owns all link state and builds a bundle of results per input.
	lhs_exec u_exec (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg),
		.q_valid(q_valid),
		.q_entry(q_entry),
		.q_pop(q_pop),
		.bnd_valid(bnd_valid),
		.bnd(bnd),
		.bnd_ready(bnd_ready)
	);

	// The output stage serialises each bundle into result transactions.
	lhs_emit u_emit (
		.clk(clk),
		.arst_n(arst_n),
		.bnd_valid(bnd_valid),
		.bnd(bnd),
		.bnd_ready(bnd_ready),
		.result(result)
	);

`ifndef SYNTHESIS
	// The execution stage only offers a bundle when the output stage can take it.
	a_bundle_taken: assert property (@(posedge clk) disable iff (!arst_n)
		bnd_valid |-> bnd_ready)
		else $error("result bundle offered while the output stage was full");

	// A tick holds the execution stage in its tick state, during which the queue is not popped.
	a_tick_two_cycles: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop && (q_entry.op == OP_TICK) |=> !q_pop)
		else $error("queue popped while a tick was still being executed");

	// A heartbeat timeout is never the final result and is followed by the disconnect.
	a_timeout_then_disc: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.ready && (result.event_res == EV_TIMEOUT)
		|=> result.valid && (result.event_res == EV_DISC) && (result.link_state == LS_DISC))
		else $error("heartbeat timeout not followed by a disconnect result");
`endif

endmodule

FILE: tb/sv/link_event_monitor.sv
module link_event_monitor import lhs_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	lhs_in_if                 item,
	lhs_out_if                result,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic              pready,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output int                mismatches,
	output int                outstanding,
	output int                results_checked
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		ev_t  ev;
		ls_t  ls;
		logic pend;
		logic last;
	} outcome_t;

	outcome_t expected_outcomes[$];
	outcome_t burst[$];
	outcome_t want;

	// Shadow of the supervisor's registers and state.
	cfg_t              cfg;
	logic [TIME_W-1:0] now_ms;
	logic [TIME_W-1:0] ping_at;
	logic [TIME_W-1:0] ack_at;
	logic [TIME_W-1:0] rx_at;
	logic [TIME_W-1:0] retry_at;
	logic              pending_ack;
	logic [1:0]        match_pos;
	ls_t               link;

	function automatic logic [TIME_W-1:0] since(input logic [TIME_W-1:0] stamp);
		return now_ms - stamp;
	endfunction

	function automatic int field_differs(input string name, input logic [31:0] exp_val,
		input logic [31:0] got_val);
		if (got_val !== exp_val) begin
			$error("%s: expected %0d, got %0d", name, exp_val, got_val);
			return 1;
		end
		return 0;
	endfunction

	task automatic note(input ev_t ev);
		burst.push_back('{ev, link, pending_ack, 1'b0});
	endtask

	task automatic restart_session();
		ping_at = now_ms;
		ack_at = now_ms;
		rx_at = now_ms;
		pending_ack = 1'b0;
		match_pos = '0;
	endtask

	task automatic go_connected();
		if (link != LS_CONN) begin
			link = LS_CONN;
			restart_session();
			note(EV_CONN);
		end
	endtask

	task automatic go_disconnected();
		if (link != LS_DISC) begin
			link = LS_DISC;
			restart_session();
			note(EV_DISC);
		end
	endtask

	task automatic take_rx(input logic [BYTE_W-1:0] b);
		rx_at = now_ms;
		if (!pending_ack)
			ack_at = now_ms;
		if (b == ACK_TEXT[match_pos]) begin
			if (match_pos == 2'd3) begin
				match_pos = '0;
				pending_ack = 1'b0;
				ack_at = now_ms;
				rx_at = now_ms;
				note(EV_ACK);
			end else
				match_pos = match_pos + 2'd1;
		end else
			match_pos = (b == ACK_TEXT[0]) ? 2'd1 : 2'd0;
	endtask

	task automatic take_tick();
		logic [TIME_W-1:0] alive;
		now_ms = now_ms + 1'b1;
		if (cfg.hb_en && link == LS_CONN) begin
			if (since(ping_at) >= cfg.ping_int) begin
				ping_at = now_ms;
				pending_ack = 1'b1;
				note(EV_PING);
			end
			if (pending_ack) begin
				alive = (ack_at > rx_at) ? ack_at : rx_at;
				if (since(alive) >= cfg.ack_to) begin
					link = LS_ERR;
					note(EV_TIMEOUT);
					go_disconnected();
				end
			end
		end
		if (cfg.auto_recon && link != LS_CONN && since(retry_at) >= cfg.retry_int) begin
			retry_at = now_ms;
			go_connected();
		end
	endtask

	task automatic predict(input logic [KIND_W-1:0] k, input logic [BYTE_W-1:0] b);
		outcome_t tail;
		burst.delete();
		case (k)
		KIND_BYTE: take_rx(b);
		KIND_TICK: take_tick();
		KIND_CONN: go_connected();
		KIND_DISC: go_disconnected();
		KIND_RECON: begin
			go_disconnected();
			go_connected();
		end
		default: ;
		endcase
		if (burst.size() == 0)
			note(EV_NONE);
		tail = burst.pop_back();
		tail.last = 1'b1;
		burst.push_back(tail);
		foreach (burst[i])
			expected_outcomes.push_back(burst[i]);
	endtask

	task automatic write_setting(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] value);
		case (addr[APB_AW-1:2])
		REG_HB_EN: cfg.hb_en = value[0];
		REG_AUTO_RECON: cfg.auto_recon = value[0];
		REG_PING_INT: cfg.ping_int = value;
		REG_ACK_TO: cfg.ack_to = value;
		REG_RETRY_INT: cfg.retry_int = value;
		default: ;
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg = '{1'b1, 1'b1, PING_INT_RST, ACK_TO_RST, RETRY_INT_RST};
			now_ms = '0;
			ping_at = '0;
			ack_at = '0;
			rx_at = '0;
			retry_at = '0;
			pending_ack = 1'b0;
			match_pos = '0;
			link = LS_DISC;
			expected_outcomes.delete();
			mismatches = 0;
			results_checked = 0;
			outstanding = 0;
		end else begin
			if (result.valid && result.ready) begin
				if (expected_outcomes.size() == 0) begin
					$error("result transaction with nothing expected: event_res %0d",
						result.event_res);
					mismatches++;
				end else begin
					want = expected_outcomes.pop_front();
					results_checked++;
					mismatches += field_differs("event_res", want.ev, result.event_res);
					mismatches += field_differs("link_state", want.ls, result.link_state);
					mismatches += field_differs("awaiting_ack", want.pend, result.awaiting_ack);
					mismatches += field_differs("last", want.last, result.last);
				end
			end
			if (item.valid && item.ready)
				predict(item.kind, item.rx_byte);
			if (psel && penable && pwrite && pready)
				write_setting(paddr, pwdata);
			outstanding = expected_outcomes.size();
		end
	end

endmodule

FILE: tb/sv/testbench.sv
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import lhs_pkg::*;

	// A register index that the block does not decode; writes to it must be ignored.
	localparam int SPARE_REG = 5;
	// Cycles without any transaction before the run is declared hung. The longest
	// legitimate quiet spell is the deliberate receiver hold-off of HOLD_OFF_CYCLES.
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int HOLD_OFF_CYCLES = 120;
	// A short settling period at the end catches any stray extra result.
	localparam int SETTLE_CYCLES = 8;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [APB_AW-1:0] paddr;
	logic [APB_DW-1:0] pwdata;
	logic [APB_DW-1:0] prdata;
	logic              pready;

	lhs_in_if  item_ch ();
	lhs_out_if result_ch ();

	int mismatches;
	int outstanding;
	int results_checked;
	int items_sent = 0;
	int settings_applied = 0;
	int quiet_cycles = 0;

	// Flow control shared between the stimulus and the receiver. The flags that the stimulus
	// sets use nonblocking assignments so that the receiver never races the stimulus process.
	logic steady_flow = 1'b0;
	logic hold_off_asked = 1'b0;
	logic hold_off_taken = 1'b0;
	int   hold_left = 0;

	// Bytes of an acknowledgement text still to be sent during the random part.
	logic [BYTE_W-1:0] pong_left[$];

	always #5ns clk = ~clk;

	link_heartbeat_supervisor dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.item    (item_ch),
		.result  (result_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	link_event_monitor event_monitor (
		.clk             (clk),
		.arst_n          (arst_n),
		.item            (item_ch),
		.result          (result_ch),
		.psel            (psel),
		.penable         (penable),
		.pwrite          (pwrite),
		.pready          (pready),
		.paddr           (paddr),
		.pwdata          (pwdata),
		.mismatches      (mismatches),
		.outstanding     (outstanding),
		.results_checked (results_checked)
	);

	// The result receiver. It normally stalls in roughly a quarter of the cycles, takes
	// everything during the steady stretch, and once in the run holds off for a long
	// stretch so that the block fills up and has to stall its input.
	always @(negedge clk) begin
		if (hold_off_asked && !hold_off_taken) begin
			hold_off_taken = 1'b1;
			hold_left = HOLD_OFF_CYCLES;
		end
		if (hold_left > 0) begin
			result_ch.ready <= 1'b0;
			hold_left--;
		end else if (steady_flow)
			result_ch.ready <= 1'b1;
		else
			result_ch.ready <= ($urandom_range(99) >= 24);
	end

	// The watchdog only counts cycles in which nothing at all moves, so a slow but
	// correct run never trips it.
	always @(posedge clk) begin
		if (!arst_n || (item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready)
			|| psel)
			quiet_cycles <= 0;
		else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("Watchdog: no transaction for %0d cycles, %0d results outstanding",
					quiet_cycles, outstanding);
				$display("Some tests failed");
				$finish;
			end
		end
	end

	// Offers one input transaction, first idling at random unless the steady stretch
	// is on. It returns at the falling edge after acceptance with valid still high, so
	// that a following transaction can be offered without a gap.
	task automatic send_item(input logic [KIND_W-1:0] k, input logic [BYTE_W-1:0] b);
		while (!steady_flow && $urandom_range(99) < 24) begin
			item_ch.valid <= 1'b0;
			@(negedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.kind <= k;
		item_ch.rx_byte <= b;
		do
			@(posedge clk);
		while (!item_ch.ready);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic send_ack_text();
		foreach (ACK_TEXT[i])
			send_item(KIND_BYTE, ACK_TEXT[i]);
	endtask

	// Stops offering and waits until every predicted result has been delivered.
	task automatic wait_drained();
		item_ch.valid <= 1'b0;
		while (outstanding != 0)
			@(negedge clk);
	endtask

	// One APB write: a setup cycle, then an access cycle that completes when pready is
	// seen. psel stays high so that writes can follow back to back; the caller releases
	// the bus.
	task automatic write_reg(input int idx, input logic [APB_DW-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= APB_AW'(idx * 4);
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		@(negedge clk);
	endtask

	// Registers are only rewritten once the block has delivered every result, which
	// leaves it idle since every input transaction yields at least one result.
	task automatic apply_settings(input logic hb, input logic auto_on,
		input logic [TIME_W-1:0] ping, input logic [TIME_W-1:0] ack_limit,
		input logic [TIME_W-1:0] retry);
		wait_drained();
		write_reg(REG_HB_EN, APB_DW'(hb));
		write_reg(REG_AUTO_RECON, APB_DW'(auto_on));
		write_reg(REG_PING_INT, ping);
		write_reg(REG_ACK_TO, ack_limit);
		write_reg(REG_RETRY_INT, retry);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		settings_applied++;
	endtask

	// Random traffic. Most bytes belong to acknowledgement texts, occasionally with a
	// corrupted byte, so that the matcher gets well past its first position; ticks are
	// frequent enough to reach the ping, timeout and retry decisions.
	task automatic run_random(input int count);
		logic [KIND_W-1:0] k;
		logic [BYTE_W-1:0] b;
		int roll;
		for (int n = 0; n < count; n++) begin
			roll = $urandom_range(99);
			b = BYTE_W'($urandom_range(255));
			if (pong_left.size() != 0 && roll < 60) begin
				k = KIND_BYTE;
				if ($urandom_range(15) != 0)
					b = pong_left.pop_front();
				else
					void'(pong_left.pop_front());
			end else if (roll < 45)
				k = KIND_TICK;
			else if (roll < 75) begin
				k = KIND_BYTE;
				if ($urandom_range(1) != 0 && pong_left.size() == 0) begin
					foreach (ACK_TEXT[i])
						pong_left.push_back(ACK_TEXT[i]);
					b = pong_left.pop_front();
				end
			end else if (roll < 95) begin
				case ($urandom_range(2))
				0: k = KIND_CONN;
				1: k = KIND_DISC;
				default: k = KIND_RECON;
				endcase
			end else
				k = KIND_W'($urandom_range(int'(KIND_RECON) + 1, (1 << KIND_W) - 1));
			send_item(k, b);
		end
		wait_drained();
	endtask

	initial begin
		arst_n = 1'b0;
		item_ch.valid = 1'b0;
		item_ch.kind = KIND_BYTE;
		item_ch.rx_byte = '0;
		result_ch.ready = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed part at the reset settings: unused kinds, a disconnect that changes
		// nothing, the byte extremes, an acknowledgement while disconnected, a repeated
		// connect, a quiet tick, and reconnects from both link states.
		send_item(KIND_W'(int'(KIND_RECON) + 1), '0);
		send_item(KIND_W'((1 << KIND_W) - 1), '1);
		send_item(KIND_DISC, '0);
		send_item(KIND_BYTE, 8'h00);
		send_item(KIND_BYTE, 8'hFF);
		send_ack_text();
		send_item(KIND_CONN, '0);
		send_item(KIND_CONN, '0);
		send_item(KIND_TICK, '0);
		send_item(KIND_RECON, '0);
		send_item(KIND_DISC, '0);
		send_item(KIND_RECON, '0);
		wait_drained();

		// Short intervals: an automatic reconnect, a ping, an acknowledgement after a
		// repeated first letter, then pings left unanswered until the heartbeat times
		// out, the link drops and is retried within the same tick.
		apply_settings(1'b1, 1'b1, 32'd1, 32'd3, 32'd0);
		send_item(KIND_DISC, '0);
		send_item(KIND_TICK, '0);
		send_item(KIND_TICK, '0);
		send_item(KIND_BYTE, ACK_TEXT[0]);
		send_ack_text();
		repeat (4)
			send_item(KIND_TICK, '0);
		wait_drained();

		// Random phases over several register settings, the extremes among them.
		apply_settings(1'b1, 1'b1, 32'd3, 32'd6, 32'd2);
		write_reg(SPARE_REG, $urandom);
		psel <= 1'b0;
		penable <= 1'b0;
		run_random(30);

		apply_settings(1'b0, 1'b1, 32'd0, 32'd0, 32'd5);
		run_random(20);

		apply_settings(1'b1, 1'b0, 32'd2, 32'd4, 32'hFFFF_FFFF);
		run_random(25);

		// A stretch with no idling on either side.
		steady_flow <= 1'b1;
		apply_settings(1'b1, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1);
		run_random(20);

		// Zero intervals make a connected tick give four results. The receiver holds
		// off for a long stretch while transactions keep being offered.
		steady_flow <= 1'b0;
		apply_settings(1'b1, 1'b1, 32'd0, 32'd0, 32'd0);
		hold_off_asked <= 1'b1;
		run_random(30);

		wait_drained();
		repeat (SETTLE_CYCLES) @(negedge clk);

		$display("Run covered %0d input transactions over %0d register settings, %0d results",
			items_sent, settings_applied + 1, results_checked);
		$display("checked, with a long receiver hold-off and a stretch without idling.");
		if (mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
